// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the max-heap priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge out of reset.
`define MHPQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition must never be seen at a clock edge out of reset.
`define MHPQ_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define MHPQ_ASSERT(label, prop)
`define MHPQ_NEVER(label, cond)
`endif
`endif

// File: hw/rtl/mhpq_pkg.sv
// Types and constants of the max-heap priority queue.
package mhpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic
    {
        ACT_INSERT  = 1'b0,
        ACT_EXTRACT = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // What one cell shows to its neighbours.
    typedef struct packed
    {
        logic  top;    // stands for +infinity above the first cell
        logic  valid;
        data_t data;
    } nbr_t;

    // Command broadcast to every cell of the row.
    typedef struct packed
    {
        logic  ins;
        logic  ext;
        data_t value;
    } cmd_t;

endpackage

// File: hw/rtl/mhpq_cell.sv
// One cell of the sorted row: holds one entry, shifts down on insert, up on extract.
module mhpq_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  mhpq_pkg::cmd_t cmd,
    input  mhpq_pkg::nbr_t prev,
    input  mhpq_pkg::nbr_t next,
    output mhpq_pkg::nbr_t own
);
    import mhpq_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    data_t data_reg;
    data_t data_next;
    logic  keep;
    logic  prev_ge;

    always_comb
    begin
        keep    = valid_reg && ($signed(data_reg) >= $signed(cmd.value));
        prev_ge = prev.top || (prev.valid && ($signed(prev.data) >= $signed(cmd.value)));
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.ins)
        begin
            if (!keep)
            begin
                if (prev_ge)
                begin
                    // new value lands here, everything below moves one down
                    valid_next = 1'b1;
                    data_next  = cmd.value;
                end
                else
                begin
                    valid_next = prev.valid;
                    data_next  = prev.data;
                end
            end
        end
        else if (cmd.ext)
        begin
            valid_next = next.valid;
            data_next  = next.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign own.top   = 1'b0;
    assign own.valid = valid_reg;
    assign own.data  = data_reg;

endmodule

// File: hw/rtl/max_heap_priority_queue.sv
// Bounded max-priority queue built as a row of sorted, self-shifting cells.
//
// Each item is either an insert of a signed value or a request for the
// largest stored value, and each gives exactly one result item: the value
// (0 for inserts, -1 when the queue is empty), a status and the entry
// count after the operation. Entries sit in a row of CAPACITY cells kept
// in descending order; an insert is placed by every cell comparing its own
// entry and its upper neighbour against the new value in parallel, and an
// extract takes the first cell while the row shifts up by one. Each
// operation updates the cells at the edge that accepts it, and the
// result appears in the cycle after acceptance. The single result register
// sets the rate: one item per cycle while results are taken as they come.
// No clearing pass after reset is needed.
module max_heap_priority_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  mhpq_pkg::data_t              value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mhpq_pkg::data_t              value_out,
    output logic [1:0]                   status,
    output logic [mhpq_pkg::COUNT_W-1:0] count
);
    import mhpq_pkg::*;

    `include "assert_macros.svh"

    nbr_t         cell_q [CAPACITY];
    cmd_t         cmd;
    logic [CAPACITY-1:0] vld;

    cnt_t         entry_count_reg;
    cnt_t         entry_count_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    data_t        value_out_reg;
    data_t        value_out_next;
    status_t      status_reg;
    status_t      status_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic         in_fire;
    logic         full;
    logic         empty;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign full     = (entry_count_reg == cnt_t'(CAPACITY));
    assign empty    = (entry_count_reg == '0);

    assign cmd.ins   = in_fire && (action == ACT_INSERT) && !full;
    assign cmd.ext   = in_fire && (action == ACT_EXTRACT) && !empty;
    assign cmd.value = value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        nbr_t prev_n;
        nbr_t next_n;

        if (i == 0)
        begin : g_first
            assign prev_n = '{top: 1'b1, valid: 1'b1, data: '0};
        end
        else
        begin : g_inner
            assign prev_n = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_n = '{top: 1'b0, valid: 1'b0, data: '0};
        end
        else
        begin : g_mid
            assign next_n = cell_q[i+1];
        end

        mhpq_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .prev  (prev_n),
            .next  (next_n),
            .own   (cell_q[i])
        );

        assign vld[i] = cell_q[i].valid;
    end

    always_comb
    begin
        entry_count_next = entry_count_reg;
        out_valid_next   = out_valid_reg;
        value_out_next   = value_out_reg;
        status_next      = status_reg;
        count_next       = count_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            value_out_next = '0;
            status_next    = ST_OK;
            if (cmd.ins)
            begin
                entry_count_next = entry_count_reg + cnt_t'(1);
            end
            else if (cmd.ext)
            begin
                entry_count_next = entry_count_reg - cnt_t'(1);
                value_out_next   = cell_q[0].data;
            end
            else if (action == ACT_INSERT)
            begin
                status_next = ST_OVERFLOW;
            end
            else
            begin
                status_next    = ST_UNDERFLOW;
                value_out_next = -32'sd1;
            end
            count_next = COUNT_W'(entry_count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
        count_reg     <= count_next;
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign count     = count_reg;

    // occupied cells form an unbroken run from the first cell
    `MHPQ_ASSERT(a_vld_contiguous, ((vld + CAPACITY'(1)) & vld) == '0)
    `MHPQ_ASSERT(a_count_match, $countones(vld) == 32'(entry_count_reg))
    `MHPQ_ASSERT(a_top_ordered,
        !vld[1] || ($signed(cell_q[0].data) >= $signed(cell_q[1].data)))
    `MHPQ_ASSERT(a_underflow,
        (in_fire && (action == ACT_EXTRACT) && empty) |=> (status_reg == ST_UNDERFLOW))

endmodule
